FILE: src/sha_pkg.sv
// shared types, constants and round functions for the sha-256 stream hasher
package sha_pkg;

    // byte source for a chunk write
    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_PAD  = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } byte_src_t;

    // commands from controller to datapath
    typedef struct packed {
        logic      put;
        byte_src_t src;
        logic      count_len;
        logic      load;
        logic      round;
        logic      fin;
        logic      out_step;
        logic      clear;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [5:0] pos;
        logic       round_last;
        logic       word_last;
    } dp_stat_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [5:0]  LEN_POS   = 6'd56;
    localparam logic [5:0]  LAST_POS  = 6'd63;
    localparam logic [5:0]  LAST_RND  = 6'd63;
    localparam logic [5:0]  SCHED_RND = 6'd16;
    localparam logic [63:0] BYTE_BITS = 64'd8;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage

FILE: src/sha_dp.sv
// sha-256 datapath: chunk window, schedule, round unit, chain hash, length
module sha_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  sha_pkg::dp_cmd_t  cmd,
    input  logic [7:0]        data_byte,
    output sha_pkg::dp_stat_t stat,
    output logic [31:0]       digest_word,
    output logic [2:0]        word_index
);

    logic [31:0] w_reg [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [5:0]  pos_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  word_reg;
    logic [63:0] len_reg;

    logic [7:0]  put_byte;
    logic [31:0] sched;
    logic [31:0] wt;
    logic [31:0] t1;
    logic [31:0] t2;

    // byte selection for a chunk write
    always_comb begin
        case (cmd.src)
            sha_pkg::SRC_DATA: put_byte = data_byte;
            sha_pkg::SRC_PAD:  put_byte = sha_pkg::PAD_BYTE;
            sha_pkg::SRC_ZERO: put_byte = 8'd0;
            sha_pkg::SRC_LEN:  put_byte = len_reg[{~pos_reg[2:0], 3'b000} +: 8];
            default:           put_byte = 8'd0;
        endcase
    end

    // schedule word and round sums
    assign sched = w_reg[0] + sha_pkg::ssig0(w_reg[1]) + w_reg[9]
                 + sha_pkg::ssig1(w_reg[14]);
    assign wt    = (rnd_reg < sha_pkg::SCHED_RND) ? w_reg[0] : sched;
    assign t1    = v_reg[7] + sha_pkg::bsig1(v_reg[4])
                 + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
                 + sha_pkg::ROUND_K[rnd_reg] + wt;
    assign t2    = sha_pkg::bsig0(v_reg[0])
                 + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // chunk window: byte writes, then a rolling schedule during rounds
    always_ff @(posedge aclk) begin
        if (cmd.put) begin
            case (pos_reg[1:0])
                2'd0:    w_reg[pos_reg[5:2]][31:24] <= put_byte;
                2'd1:    w_reg[pos_reg[5:2]][23:16] <= put_byte;
                2'd2:    w_reg[pos_reg[5:2]][15:8]  <= put_byte;
                default: w_reg[pos_reg[5:2]][7:0]   <= put_byte;
            endcase
        end else if (cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wt;
        end
    end

    // working variables
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v_reg <= h_reg;
        end else if (cmd.round) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // control counters, chain hash and length
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            h_reg    <= sha_pkg::INIT_HASH;
            pos_reg  <= '0;
            rnd_reg  <= '0;
            word_reg <= '0;
            len_reg  <= '0;
        end else begin
            if (cmd.put) begin
                pos_reg <= pos_reg + 6'd1;
            end
            if (cmd.count_len) begin
                len_reg <= len_reg + sha_pkg::BYTE_BITS;
            end
            if (cmd.load) begin
                rnd_reg <= '0;
            end else if (cmd.round) begin
                rnd_reg <= rnd_reg + 6'd1;
            end
            if (cmd.fin) begin
                for (int i = 0; i < 8; i++) begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
            if (cmd.out_step) begin
                word_reg <= word_reg + 3'd1;
            end
        end
    end

    assign stat.pos        = pos_reg;
    assign stat.round_last = (rnd_reg == sha_pkg::LAST_RND);
    assign stat.word_last  = (word_reg == 3'd7);
    assign digest_word     = h_reg[word_reg];
    assign word_index      = word_reg;

endmodule

FILE: src/sha_ctrl.sv
// sha-256 controller: intake, padding, compression and digest sequencing
module sha_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_byte_valid,
    input  logic              s_last,
    output logic              m_valid,
    input  logic              m_ready,
    input  sha_pkg::dp_stat_t stat,
    output sha_pkg::dp_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_COMP  = 7'b0000010,
        ST_FIN   = 7'b0000100,
        ST_PAD1  = 7'b0001000,
        ST_PADZ  = 7'b0010000,
        ST_PADL  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    state_t resume_reg, resume_next;

    logic full;

    assign full    = (stat.pos == sha_pkg::LAST_POS);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    // next state and datapath commands
    always_comb begin
        state_next  = state_reg;
        resume_next = resume_reg;
        cmd         = '0;
        cmd.src     = sha_pkg::SRC_DATA;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_byte_valid) begin
                        cmd.put       = 1'b1;
                        cmd.count_len = 1'b1;
                    end
                    if (s_byte_valid && full) begin
                        cmd.load    = 1'b1;
                        state_next  = ST_COMP;
                        resume_next = s_last ? ST_PAD1 : ST_IDLE;
                    end else if (s_last) begin
                        state_next = ST_PAD1;
                    end
                end
            end
            ST_PAD1: begin
                cmd.put = 1'b1;
                cmd.src = sha_pkg::SRC_PAD;
                if (full) begin
                    cmd.load    = 1'b1;
                    state_next  = ST_COMP;
                    resume_next = ST_PADZ;
                end else begin
                    state_next = ST_PADZ;
                end
            end
            ST_PADZ: begin
                if (stat.pos == sha_pkg::LEN_POS) begin
                    state_next = ST_PADL;
                end else begin
                    cmd.put = 1'b1;
                    cmd.src = sha_pkg::SRC_ZERO;
                    if (full) begin
                        cmd.load    = 1'b1;
                        state_next  = ST_COMP;
                        resume_next = ST_PADZ;
                    end
                end
            end
            ST_PADL: begin
                cmd.put = 1'b1;
                cmd.src = sha_pkg::SRC_LEN;
                if (full) begin
                    cmd.load    = 1'b1;
                    state_next  = ST_COMP;
                    resume_next = ST_OUT;
                end
            end
            ST_COMP: begin
                cmd.round = 1'b1;
                if (stat.round_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = resume_reg;
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (stat.word_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.out_step = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            resume_reg <= ST_IDLE;
        end else begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
        end
    end

    // the last of a chunk's 64 rounds always leads straight to the chain update
    a_round_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMP && stat.round_last) |=> (state_reg == ST_FIN))
        else $error("compression did not end in chain update");

    // intake and digest output never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("intake open during digest output");

    // final digest transfer returns to intake with a fresh chain
    a_out_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && stat.word_last) |=> (s_ready && stat.pos == 6'd0))
        else $error("digest end did not restart hasher");

    // a full chunk write always starts a compression
    a_full_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.put && full) |=> (state_reg == ST_COMP))
        else $error("full chunk not compressed");

endmodule

FILE: src/sha256_stream_hasher_top.sv
// top level of the sha-256 stream hasher
//
// Input channel (s_): one message byte per transfer with s_byte_valid set;
// s_last closes the message. A transfer with s_last and no byte closes the
// message without adding one (an empty message if nothing came before).
// Output channel (m_): after a closed message, eight transfers carry the
// digest words, m_word_index 0 to 7, m_last_word set on the eighth.
// Intake: every 64th byte also starts a compression of the chunk and a
// chain update, during which s_ready is low. The round unit does one
// round a cycle.
// After the last transfer: padding writes one byte a cycle up to the end
// of the chunk, but for a state without a write before the length bytes,
// and is held by a compression whenever a chunk fills first; the last
// compression and chain update precede m_valid.
// While the receiver stalls the digest word holds and no input is taken.
// After the eighth word the hasher returns to the initial hash state.
// Reset (aresetn low, synchronous) clears the hasher to the same state.
module sha256_stream_hasher_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_valid,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    sha_pkg::dp_cmd_t  cmd;
    sha_pkg::dp_stat_t stat;

    sha_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_data_byte),
        .stat        (stat),
        .digest_word (m_digest_word),
        .word_index  (m_word_index)
    );

    sha_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_valid (s_byte_valid),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    assign m_last_word = stat.word_last;

endmodule

FILE: tb/tb.sv
// self-checking testbench for the sha-256 stream hasher
module tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_byte_valid = 1'b0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last_word;
    } digest_word_t;

    // digest predictor plus queue of expected digest words
    class digest_scoreboard;
        logic [31:0]  hash_state [8];
        logic [31:0]  block_words [16];
        logic [5:0]   fill_count;
        logic [63:0]  bit_length;
        digest_word_t pending_words [$];
        int           error_count;
        int           digests_seen;

        function new();
            error_count = 0;
            digests_seen = 0;
            clear_state();
        endfunction

        function void clear_state();
            foreach (hash_state[i]) hash_state[i] = sha_pkg::INIT_HASH[i];
            foreach (block_words[i]) block_words[i] = '0;
            fill_count = '0;
            bit_length = '0;
        endfunction

        function logic [31:0] rotr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress_block();
            logic [31:0] wv [8];
            logic [31:0] sched [64];
            logic [31:0] t1, t2;
            for (int t = 0; t < 64; t++) begin
                if (t < 16) begin
                    sched[t] = block_words[t];
                end else begin
                    sched[t] = sched[t-16] + sched[t-7]
                        + (rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3))
                        + (rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10));
                end
            end
            foreach (wv[i]) wv[i] = hash_state[i];
            for (int t = 0; t < 64; t++) begin
                t1 = wv[7] + (rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25))
                   + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + sha_pkg::ROUND_K[t] + sched[t];
                t2 = (rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22))
                   + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
                wv[7] = wv[6]; wv[6] = wv[5]; wv[5] = wv[4]; wv[4] = wv[3] + t1;
                wv[3] = wv[2]; wv[2] = wv[1]; wv[1] = wv[0]; wv[0] = t1 + t2;
            end
            foreach (hash_state[i]) hash_state[i] += wv[i];
        endfunction

        function void append_byte(logic [7:0] b);
            block_words[fill_count[5:2]][8*(3 - fill_count[1:0]) +: 8] = b;
            if (fill_count == 6'd63) compress_block();
            fill_count++;
        endfunction

        // note one accepted input transfer
        function void note_input(logic [7:0] b, logic has_byte, logic closes);
            logic [63:0] len;
            digest_word_t dw;
            if (has_byte) begin
                append_byte(b);
                bit_length += 64'd8;
            end
            if (!closes) return;
            len = bit_length;
            append_byte(8'h80);
            while (fill_count != 6'd56) append_byte(8'h00);
            for (int i = 7; i >= 0; i--) append_byte(len[8*i +: 8]);
            for (int i = 0; i < 8; i++) begin
                dw.word = hash_state[i];
                dw.index = 3'(i);
                dw.last_word = (i == 7);
                pending_words.push_back(dw);
            end
            clear_state();
        endfunction

        // compare one output transfer with the oldest expectation
        function void check_word(logic [31:0] w, logic [2:0] idx, logic lw);
            digest_word_t dw;
            if (pending_words.size() == 0) begin
                $error("unexpected digest word %h", w);
                error_count++;
                return;
            end
            dw = pending_words.pop_front();
            if (w !== dw.word) begin
                $error("digest_word expected %h actual %h", dw.word, w);
                error_count++;
            end
            if (idx !== dw.index) begin
                $error("word_index expected %0d actual %0d", dw.index, idx);
                error_count++;
            end
            if (lw !== dw.last_word) begin
                $error("last_word expected %0b actual %0b", dw.last_word, lw);
                error_count++;
            end
            if (dw.last_word) digests_seen++;
        endfunction
    endclass

    digest_scoreboard sb = new();
    int idle_cycles = 0;
    int items_sent = 0;
    int burst_left = 0;
    bit stall_enable = 1'b1;

    sha256_stream_hasher_top i_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // monitor both channels and run the watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data_byte, s_byte_valid, s_last);
            if (m_valid && m_ready)
                sb.check_word(m_digest_word, m_word_index, m_last_word);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 20000) begin
                $display("FAIL sha256_stream_hasher_top");
                $finish;
            end
        end
    end

    // receiver stalls when enabled: periodic windows plus random drops
    int stall_phase = 0;
    always @(negedge aclk) begin
        stall_phase = (stall_phase + 1) % 23;
        if (!stall_enable) m_ready <= 1'b1;
        else m_ready <= (stall_phase >= 6) && ($urandom_range(0, 3) != 0);
    end

    // send one transfer, with bursts and random gaps
    task automatic send_item(logic [7:0] b, logic has_byte, logic closes);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_byte_valid <= has_byte;
        s_last <= closes;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // a whole message of n random bytes; optionally close with an empty transfer
    task automatic send_message(int n, bit empty_close);
        for (int i = 0; i < n; i++)
            send_item(8'($urandom), 1'b1, !empty_close && (i == n - 1));
        if (empty_close || n == 0) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // sender goes quiet until every expected word has come
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(negedge aclk);
    endtask

    initial begin
        int n;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty message, byte extremes, ignored transfers, one-byte close
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'ha5, 1'b1, 1'b0);
        send_item(8'h3c, 1'b0, 1'b0);
        send_item(8'hc3, 1'b1, 1'b1);
        send_item(8'h81, 1'b1, 1'b0);
        send_item(8'h7e, 1'b0, 1'b1);
        // hold off until the digests are out
        wait_drained();
        repeat (10) @(negedge aclk);

        // directed lengths around the padding boundaries
        stall_enable = 1'b0;
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        stall_enable = 1'b1;
        send_message(64, 1'b1);

        // random messages, mostly short, with noise transfers mixed in
        while (items_sent < 370) begin
            case ($urandom_range(0, 9))
                0: send_item(8'($urandom), 1'b0, 1'b0);
                1: n = $urandom_range(60, 130);
                default: n = $urandom_range(0, 20);
            endcase
            send_message(n, $urandom_range(0, 3) == 0);
        end

        wait_drained();
        repeat (300) @(negedge aclk);
        $display("run covered %0d transfers and %0d digests, including empty", items_sent,
                 sb.digests_seen);
        $display("messages and lengths at the one- and two-chunk padding boundaries");
        if (sb.error_count == 0 && sb.pending_words.size() == 0) begin
            $display("PASS sha256_stream_hasher_top");
        end else begin
            $display("FAIL sha256_stream_hasher_top");
        end
        $finish;
    end
endmodule
